[rtl/pfe_pkg.sv]
// pfe_pkg: shared types and constants of the postfix expression evaluator
// character codes, status codes, operator codes, controller/datapath interface structs
// depends on nothing
package pfe_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned DIV_STEPS = 32;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_ADD   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_SUB   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_TERM  = 8'h3F;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_UNDERFLOW = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_DIVZERO   = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic digit;
      logic space;
      logic op_start;
      logic exec;
      logic div_wb;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_digit;
      logic is_space;
      logic is_op;
      logic is_term;
      logic cnt_ge2;
      logic needs_div;
      logic div_done;
      logic out_busy;
   } sts_type;

   // keeps only the first error of an expression
   function automatic status_type note_error(status_type cur, status_type code);
      note_error = (cur == ST_OK) ? code : cur;
   endfunction

endpackage

[rtl/pfe_divider.sv]
// pfe_divider: iterative signed 32-bit divider, one quotient bit per cycle
// truncates toward zero, caller guarantees a nonzero divisor
// depends on pfe_pkg
module pfe_divider
   import pfe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic [DATA_W-1:0] quotient,
   output logic              done
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    dsr_ff, dsr_in;
   logic                 neg_ff, neg_in;
   logic [DATA_W:0]      rem_sh;
   logic [DATA_W:0]      diff;

   assign rem_sh = {rem_ff, quo_ff[DATA_W-1]};
   assign diff   = rem_sh - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = DIV_CNT_W'(DIV_STEPS - 1);
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
         dsr_in  = divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         // restoring step
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         step_in = step_ff - DIV_CNT_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
      neg_ff  <= neg_in;
   end

   assign quotient = neg_ff ? (~quo_ff + DATA_W'(1)) : quo_ff;
   assign done     = done_ff;

endmodule

[rtl/pfe_datapath.sv]
// pfe_datapath: value stack memory, number accumulator, alu, divider and result register
// acts on commands from pfe_controller and reports status back
// depends on pfe_pkg and pfe_divider
module pfe_datapath
   import pfe_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [CHAR_W-1:0]        req_ch,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic [STATUS_W-1:0]      rsp_status
);

   localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DATA_W-1:0]   acc_ff, acc_in;
   logic                lwd_ff, lwd_in;
   status_type          err_ff, err_in;
   op_type              op_ff, op_in;
   logic [DATA_W-1:0]   rd_top_ff, rd_nxt_ff;
   logic                out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]   out_value_ff, out_value_in;
   status_type          out_status_ff, out_status_in;

   logic [CNT_W-1:0]  cnt_m1, cnt_m2;
   logic [IDX_W-1:0]  idx_top, idx_nxt;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   logic [DATA_W-1:0] wr_data;
   logic [DATA_W-1:0] alu_res;
   logic              div_start;
   logic [DATA_W-1:0] div_quo;
   logic              div_done;
   logic              full;
   logic              out_load;
   op_type            ch_op;

   assign cnt_m1  = cnt_ff - CNT_W'(1);
   assign cnt_m2  = cnt_ff - CNT_W'(2);
   assign idx_top = cnt_m1[IDX_W-1:0];
   assign idx_nxt = cnt_m2[IDX_W-1:0];
   assign full    = (cnt_ff == CNT_W'(STACK_DEPTH));

   // character classes
   always_comb begin
      sts.is_digit  = (req_ch >= CH_ZERO) && (req_ch <= CH_NINE);
      sts.is_space  = (req_ch == CH_SPACE);
      sts.is_op     = (req_ch == CH_ADD) || (req_ch == CH_SUB) ||
                      (req_ch == CH_MUL) || (req_ch == CH_DIV);
      sts.is_term   = (req_ch == CH_TERM);
      sts.cnt_ge2   = (cnt_ff >= CNT_W'(2));
      sts.needs_div = (op_ff == OP_DIV) && (rd_top_ff != '0);
      sts.div_done  = div_done;
      sts.out_busy  = out_valid_ff && !rsp_ready;
   end

   always_comb begin
      case (req_ch)
         CH_ADD:  ch_op = OP_ADD;
         CH_SUB:  ch_op = OP_SUB;
         CH_MUL:  ch_op = OP_MUL;
         CH_DIV:  ch_op = OP_DIV;
         default: ch_op = OP_ADD;
      endcase
   end

   // left operand is the deeper entry
   always_comb begin
      case (op_ff)
         OP_ADD:  alu_res = rd_nxt_ff + rd_top_ff;
         OP_SUB:  alu_res = rd_nxt_ff - rd_top_ff;
         OP_MUL:  alu_res = rd_nxt_ff * rd_top_ff;
         default: alu_res = '0;
      endcase
   end

   pfe_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_nxt_ff),
      .divisor  (rd_top_ff),
      .quotient (div_quo),
      .done     (div_done)
   );

   always_comb begin
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      lwd_in    = lwd_ff;
      err_in    = err_ff;
      op_in     = op_ff;
      wr_en     = 1'b0;
      wr_idx    = idx_nxt;
      wr_data   = alu_res;
      div_start = 1'b0;
      out_load  = 1'b0;

      if (cmd.digit) begin
         acc_in = (acc_ff << 3) + (acc_ff << 1) + DATA_W'(req_ch[3:0]);
         lwd_in = 1'b1;
      end

      if (cmd.space) begin
         if (lwd_ff) begin
            if (full) begin
               err_in = note_error(err_ff, ST_OVERFLOW);
            end else begin
               wr_en   = 1'b1;
               wr_idx  = cnt_ff[IDX_W-1:0];
               wr_data = acc_ff;
               cnt_in  = cnt_ff + CNT_W'(1);
            end
            acc_in = '0;
         end
         lwd_in = 1'b0;
      end

      if (cmd.op_start) begin
         lwd_in = 1'b0;
         op_in  = ch_op;
         if (!sts.cnt_ge2) begin
            err_in = note_error(err_ff, ST_UNDERFLOW);
         end
      end

      if (cmd.exec) begin
         if (op_ff == OP_DIV) begin
            if (rd_top_ff == '0) begin
               err_in  = note_error(err_ff, ST_DIVZERO);
               wr_en   = 1'b1;
               wr_data = '0;
               cnt_in  = cnt_m1;
            end else begin
               div_start = 1'b1;
            end
         end else begin
            wr_en  = 1'b1;
            cnt_in = cnt_m1;
         end
      end

      if (cmd.div_wb) begin
         wr_en   = 1'b1;
         wr_data = div_quo;
         cnt_in  = cnt_m1;
      end

      if (cmd.load_out) begin
         out_load = 1'b1;
         cnt_in   = '0;
         acc_in   = '0;
         lwd_in   = 1'b0;
         err_in   = ST_OK;
      end
   end

   // result register
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_value_in = (cnt_ff != '0) ? rd_top_ff : '0;
         if (err_ff != ST_OK) begin
            out_status_in = err_ff;
         end else if (cnt_ff == '0) begin
            out_status_in = ST_EMPTY;
         end else begin
            out_status_in = ST_OK;
         end
      end
   end

   // stack memory, one write and two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_idx] <= wr_data;
      end
      rd_top_ff <= stack_mem[idx_top];
      rd_nxt_ff <= stack_mem[idx_nxt];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         acc_ff       <= '0;
         lwd_ff       <= 1'b0;
         err_ff       <= ST_OK;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         lwd_ff       <= lwd_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
      op_ff         <= op_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_value  = $signed(out_value_ff);
   assign rsp_status = out_status_ff;

endmodule

[rtl/pfe_controller.sv]
// pfe_controller: sequencing state machine of the postfix expression evaluator
// issues datapath commands per character and handles the input handshake
// depends on pfe_pkg
module pfe_controller
   import pfe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_DIV  = 5'b00100,
      S_TRD  = 5'b01000,
      S_TOUT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (sts.is_digit) begin
                  cmd.digit = 1'b1;
               end else if (sts.is_space) begin
                  cmd.space = 1'b1;
               end else if (sts.is_op) begin
                  cmd.op_start = 1'b1;
                  if (sts.cnt_ge2) begin
                     state_in = S_EXEC;
                  end
               end else if (sts.is_term) begin
                  // push a pending number first
                  cmd.space = 1'b1;
                  state_in  = S_TRD;
               end
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.needs_div ? S_DIV : S_IDLE;
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.div_wb = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_TRD: begin
            state_in = S_TOUT;
         end
         S_TOUT: begin
            if (!sts.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/postfix_expression_evaluator_core.sv]
// postfix_expression_evaluator_core: top level of the postfix expression evaluator
// joins the controller and the datapath
// depends on pfe_pkg, pfe_controller, pfe_datapath
//
// usage: characters arrive on the req_ channel (req_ch, valid/ready), one transfer
// per character; results leave on the rsp_ channel (rsp_value, rsp_status), one
// transfer per '?' terminator. digits, spaces and ignored characters are taken
// without leaving S_IDLE; + - * read the operands out of the stack memory, then the
// alu writes back; / with a nonzero divisor runs the 32-step restoring divider. '?'
// pushes a pending number, reads the top entry and, once the result register is
// free, loads it, then clears the expression state.
// the result sits in an output register: while it waits for rsp_ready the block
// keeps taking characters; only a second '?' holds in its final state until the
// previous result has been taken.
// reset (synchronous, active high) empties the stack, the accumulator, the error
// flag and the result register. stack entries are not cleared and need no pass
// after reset; entries at or above the fill count are never used.
module postfix_expression_evaluator_core
   import pfe_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CHAR_W-1:0]        req_ch,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic [STATUS_W-1:0]      rsp_status
);

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   pfe_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // stack, accumulator, alu, divider and result register
   pfe_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

endmodule

[rtl/pfe_checker.sv]
// pfe_checker: port-level assertions for postfix_expression_evaluator_core
// attached by the bind statement at the end of this file
// depends on pfe_pkg
module pfe_checker
   import pfe_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [CHAR_W-1:0]        req_ch,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_value,
   input logic [STATUS_W-1:0]      rsp_status
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("result changed while stalled");

   // no result right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an empty expression reports zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_value == '0)
      else $error("empty status with nonzero value");

   // after a digit the block is ready again in the next cycle
   a_digit_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_ch >= CH_ZERO && req_ch <= CH_NINE |=> req_ready)
      else $error("not ready after digit");

   // the terminator always occupies the sequencer
   a_term_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_ch == CH_TERM |=> !req_ready)
      else $error("ready right after terminator");

endmodule

bind postfix_expression_evaluator_core pfe_checker u_pfe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .req_ch     (req_ch),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_value  (rsp_value),
   .rsp_status (rsp_status)
);
